[rtl/table_interpolator_binary_search_defines.svh]
// ----------------------------------------------------------------------------
// Table interpolator assertion macros
// Shared helpers for the concurrent checks in the RTL folder.
// ----------------------------------------------------------------------------
`ifndef TABLE_INTERPOLATOR_BINARY_SEARCH_DEFINES_SVH
`define TABLE_INTERPOLATOR_BINARY_SEARCH_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define TIB_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define TIB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/tib_pkg.sv]
// ----------------------------------------------------------------------------
// tib_pkg
// Widths, codes and shared types of the table interpolator.
// ----------------------------------------------------------------------------
package tib_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 512;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int N_W         = ADDR_W + 1;

	// field widths
	localparam int POS_W  = 19;
	localparam int VAL_W  = 17;
	localparam int CNT_W  = 10;
	localparam int IDX_W  = 9;
	localparam int CFG_W  = 19;
	localparam int CIDX_W = 1;
	localparam int RGN_W  = 2;
	localparam int ENT_W  = POS_W + VAL_W;
	localparam int SQ_W   = 2 * POS_W;

	// divider geometry
	localparam int DIVD_W   = POS_W + VAL_W;
	localparam int DVS_W    = POS_W;
	localparam int DIV_STEPS = DIVD_W / 2;
	localparam int DCNT_W   = $clog2(DIV_STEPS + 1);

	// series 1 - x^2/6 in Q.16: (x*x >> 17) / 3, the divide by 3 as a
	// reciprocal multiply, exact for a dividend below 2^21
	localparam int SERIES_SHIFT = 17;
	localparam int SQH_W        = SQ_W - SERIES_SHIFT;
	localparam int RECIP_W      = 21;
	localparam int RECIP_SHIFT  = 22;
	localparam int SPROD_W      = SQH_W + RECIP_W;
	localparam int TERM_W       = SPROD_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] SERIES_RECIP = RECIP_W'(1398102);
	localparam logic [VAL_W-1:0] ONE_Q16 = VAL_W'(65536);

	// register reset values
	localparam logic [CNT_W-1:0] ENTRY_COUNT_RST = CNT_W'(2);
	localparam logic [POS_W-1:0] BOUNDARY_RST    = POS_W'(239454);

	// register indexes
	localparam logic [CIDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
	localparam logic [CIDX_W-1:0] CFG_BOUNDARY    = 1'b1;

	// opcodes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// result regions
	localparam logic [RGN_W-1:0] RGN_SERIES   = 2'd0;
	localparam logic [RGN_W-1:0] RGN_INTERP   = 2'd1;
	localparam logic [RGN_W-1:0] RGN_BOUNDARY = 2'd2;
	localparam logic [RGN_W-1:0] RGN_LAST     = 2'd3;

	// divide request from the sequencer
	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DVS_W-1:0]  divisor;
	} div_req_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

[rtl/tib_ram.sv]
// ----------------------------------------------------------------------------
// tib_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tib_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[rtl/tib_div.sv]
// ----------------------------------------------------------------------------
// tib_div
// Iterative unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module tib_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tib_pkg::div_req_t req,
	output tib_pkg::div_rsp_t rsp
);

	logic [tib_pkg::DVS_W:0]    rem_q;
	logic [tib_pkg::DIVD_W-1:0] quo_q;
	logic [tib_pkg::DVS_W-1:0]  dvs_q;
	logic [tib_pkg::DCNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [tib_pkg::DVS_W:0]    rem_d;
	logic [tib_pkg::DIVD_W-1:0] quo_d;

	// two shift-compare-subtract steps
	always_comb begin
		rem_d = rem_q;
		quo_d = quo_q;
		for (int k = 0; k < 2; k++) begin
			rem_d = {rem_d[tib_pkg::DVS_W-1:0], quo_d[tib_pkg::DIVD_W-1]};
			quo_d = {quo_d[tib_pkg::DIVD_W-2:0], 1'b0};
			if (rem_d >= {1'b0, dvs_q}) begin
				rem_d    = rem_d - {1'b0, dvs_q};
				quo_d[0] = 1'b1;
			end
		end
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= tib_pkg::DCNT_W'(tib_pkg::DIV_STEPS);
				rem_q  <= '0;
				quo_q  <= req.dividend;
				dvs_q  <= req.divisor;
			end else if (busy_q) begin
				rem_q <= rem_d;
				quo_q <= quo_d;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tib_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[rtl/table_interpolator_binary_search.sv]
// ----------------------------------------------------------------------------
// table_interpolator_binary_search
// Breakpoint table with binary search and linear interpolation.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): opcode 0 loads entry_index with
//    position/entry_value, opcode 1 queries the value at position.
//  - Output channel (out_valid/out_ready): one item (value, region) per query,
//    none per load.
//  - Config port (cfg_write/cfg_index/cfg_data): entry_count, boundary_position;
//    write only while the block is idle.
//  - A load is written on acceptance. A query reads entry 0 and then entry n-1:
//    a series answer follows the entry 0 read, a boundary or past-last answer
//    the entry n-1 read. An interpolated query adds the search probes, two
//    pair reads, a multiply and the divide, paced by the table RAM read port
//    and the iterative divider; one item is in work at a time.
//  - The result sits in an output register; the next item is accepted while
//    it waits. A finished query holds until that register is free.
//  - Reset sets entry_count to 2 and boundary_position to 239454; the table
//    contents are undefined until loaded and need no clearing.
// ----------------------------------------------------------------------------
`include "table_interpolator_binary_search_defines.svh"

module table_interpolator_binary_search (
	input  logic                        clk,
	input  logic                        arst_n,
	// input items
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        opcode,
	input  logic [tib_pkg::IDX_W-1:0]   entry_index,
	input  logic [tib_pkg::POS_W-1:0]   position,
	input  logic [tib_pkg::VAL_W-1:0]   entry_value,
	// result items
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tib_pkg::VAL_W-1:0]   value,
	output logic [tib_pkg::RGN_W-1:0]   region,
	// configuration
	input  logic                        cfg_write,
	input  logic [tib_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [tib_pkg::CFG_W-1:0]   cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_FIRST, S_LAST, S_PROBE, S_CMP, S_RD1,
		S_PAIR, S_MUL, S_DSTART, S_DIV, S_DONE
	} state_t;

	state_t state_q;

	// config registers
	logic [tib_pkg::CNT_W-1:0] entry_count_q;
	logic [tib_pkg::POS_W-1:0] boundary_q;

	// query working registers
	logic [tib_pkg::POS_W-1:0]  x_q;
	logic [tib_pkg::SQ_W-1:0]   sq_q;
	logic [tib_pkg::N_W-1:0]    lo_q;
	logic [tib_pkg::N_W-1:0]    hi1_q;
	logic [tib_pkg::ADDR_W-1:0] i_q;
	logic [tib_pkg::POS_W-1:0]  x0_q;
	logic [tib_pkg::VAL_W-1:0]  v0_q;
	logic [tib_pkg::POS_W-1:0]  dx_q;
	logic signed [tib_pkg::VAL_W:0] dv_q;
	logic [tib_pkg::DVS_W-1:0]  den_q;
	logic signed [tib_pkg::DIVD_W+1:0] prod_q;
	logic                       neg_q;
	logic [tib_pkg::VAL_W-1:0]  res_q;
	logic [tib_pkg::RGN_W-1:0]  rgn_q;

	// output register
	logic                       out_valid_q;
	logic [tib_pkg::VAL_W-1:0]  value_q;
	logic [tib_pkg::RGN_W-1:0]  region_q;

	// RAM and divider
	logic                       ram_we;
	logic [tib_pkg::ADDR_W-1:0] ram_raddr;
	logic [tib_pkg::ENT_W-1:0]  ram_rdata;
	logic [tib_pkg::POS_W-1:0]  rpos;
	logic [tib_pkg::VAL_W-1:0]  rval;
	tib_pkg::div_req_t          div_req;
	tib_pkg::div_rsp_t          div_rsp;

	// derived control
	logic                       in_acc;
	logic [tib_pkg::N_W-1:0]    n_eff;
	logic [tib_pkg::N_W-1:0]    n_m1;
	logic [tib_pkg::N_W-1:0]    n_m2;
	logic [tib_pkg::N_W-1:0]    span;
	logic [tib_pkg::N_W-1:0]    mid;
	logic [tib_pkg::N_W-1:0]    i_pre;
	logic [tib_pkg::N_W-1:0]    i_sel;
	logic                       search_on;
	logic [tib_pkg::DIVD_W+1:0] prod_mag;
	logic [tib_pkg::VAL_W:0]    q_signed;
	logic [tib_pkg::VAL_W:0]    interp_sum;
	logic [tib_pkg::SPROD_W-1:0] series_prod;
	logic [tib_pkg::TERM_W-1:0] series_term;
	logic [tib_pkg::VAL_W-1:0]  series_res;
	logic                       out_free;
	logic                       out_load;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == S_DONE) && out_free;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= tib_pkg::ENTRY_COUNT_RST;
			boundary_q    <= tib_pkg::BOUNDARY_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tib_pkg::CFG_ENTRY_COUNT: entry_count_q <= cfg_data[tib_pkg::CNT_W-1:0];
				tib_pkg::CFG_BOUNDARY:    boundary_q    <= cfg_data[tib_pkg::POS_W-1:0];
				default: ;
			endcase
		end
	end

	// entry count clamped to 2..depth
	always_comb begin
		if (entry_count_q < tib_pkg::CNT_W'(2)) begin
			n_eff = tib_pkg::N_W'(2);
		end else if (32'(entry_count_q) > tib_pkg::TABLE_DEPTH) begin
			n_eff = tib_pkg::N_W'(tib_pkg::TABLE_DEPTH);
		end else begin
			n_eff = tib_pkg::N_W'(entry_count_q);
		end
		n_m1 = n_eff - tib_pkg::N_W'(1);
		n_m2 = n_eff - tib_pkg::N_W'(2);
	end

	// search midpoint and final lower index
	always_comb begin
		search_on = (lo_q < hi1_q);
		span      = hi1_q - lo_q - tib_pkg::N_W'(1);
		mid       = lo_q + (span >> 1);
		i_pre     = (lo_q == '0) ? '0 : lo_q - tib_pkg::N_W'(1);
		i_sel     = (i_pre > n_m2) ? n_m2 : i_pre;
	end

	// RAM read address by state
	always_comb begin
		case (state_q)
			S_FIRST: ram_raddr = n_m1[tib_pkg::ADDR_W-1:0];
			S_PROBE: ram_raddr = search_on ? mid[tib_pkg::ADDR_W-1:0]
			                               : i_sel[tib_pkg::ADDR_W-1:0];
			S_RD1:   ram_raddr = i_q + tib_pkg::ADDR_W'(1);
			default: ram_raddr = '0;
		endcase
	end

	assign ram_we = in_acc && (opcode == tib_pkg::OP_LOAD)
	                && (32'(entry_index) < tib_pkg::TABLE_DEPTH);
	assign rpos   = ram_rdata[tib_pkg::ENT_W-1 -: tib_pkg::POS_W];
	assign rval   = ram_rdata[tib_pkg::VAL_W-1:0];

	tib_ram #(
		.WIDTH(tib_pkg::ENT_W),
		.DEPTH(tib_pkg::TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tib_pkg::ADDR_W'(entry_index)),
		.wdata ({position, entry_value}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// series term: (x*x >> 17) / 3 by reciprocal multiply, saturated at zero
	always_comb begin
		series_prod = tib_pkg::SPROD_W'(sq_q[tib_pkg::SQ_W-1:tib_pkg::SERIES_SHIFT])
		              * tib_pkg::SPROD_W'(tib_pkg::SERIES_RECIP);
		series_term = series_prod[tib_pkg::SPROD_W-1:tib_pkg::RECIP_SHIFT];
		series_res  = (series_term[tib_pkg::TERM_W-1:tib_pkg::VAL_W-1] != '0) ? '0 :
		              tib_pkg::ONE_Q16 - series_term[tib_pkg::VAL_W-1:0];
	end

	// divide request for the interpolation step
	assign prod_mag = prod_q[tib_pkg::DIVD_W+1] ? 
	                  (tib_pkg::DIVD_W+2)'(-prod_q) : (tib_pkg::DIVD_W+2)'(prod_q);

	always_comb begin
		div_req.start    = (state_q == S_DSTART);
		div_req.dividend = prod_mag[tib_pkg::DIVD_W-1:0];
		div_req.divisor  = den_q;
	end

	tib_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// result forming after the divide
	always_comb begin
		q_signed   = neg_q ? -div_rsp.quotient[tib_pkg::VAL_W:0]
		                   : div_rsp.quotient[tib_pkg::VAL_W:0];
		interp_sum = {1'b0, v0_q} + q_signed;
	end

	// query sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			region_q    <= '0;
			x_q         <= '0;
			sq_q        <= '0;
			lo_q        <= '0;
			hi1_q       <= '0;
			i_q         <= '0;
			x0_q        <= '0;
			v0_q        <= '0;
			dx_q        <= '0;
			dv_q        <= '0;
			den_q       <= '0;
			prod_q      <= '0;
			neg_q       <= 1'b0;
			res_q       <= '0;
			rgn_q       <= '0;
		end else begin
			// output register: take a finished item, else clear once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
				value_q     <= res_q;
				region_q    <= rgn_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (opcode == tib_pkg::OP_QUERY)) begin
						x_q     <= position;
						sq_q    <= tib_pkg::SQ_W'(position) * tib_pkg::SQ_W'(position);
						state_q <= S_FIRST;
					end
				end
				// entry 0 present: series test
				S_FIRST: begin
					if ((x_q == '0) || (x_q <= rpos)) begin
						res_q   <= series_res;
						rgn_q   <= tib_pkg::RGN_SERIES;
						state_q <= S_DONE;
					end else begin
						state_q <= S_LAST;
					end
				end
				// entry n-1 present: boundary and past-last tests
				S_LAST: begin
					if (x_q >= boundary_q) begin
						res_q   <= '0;
						rgn_q   <= tib_pkg::RGN_BOUNDARY;
						state_q <= S_DONE;
					end else if (x_q >= rpos) begin
						res_q   <= rval;
						rgn_q   <= tib_pkg::RGN_LAST;
						state_q <= S_DONE;
					end else begin
						lo_q    <= '0;
						hi1_q   <= n_eff;
						state_q <= S_PROBE;
					end
				end
				// issue a probe, or the lower entry of the pair
				S_PROBE: begin
					if (search_on) begin
						i_q     <= mid[tib_pkg::ADDR_W-1:0];
						state_q <= S_CMP;
					end else begin
						i_q     <= i_sel[tib_pkg::ADDR_W-1:0];
						state_q <= S_RD1;
					end
				end
				S_CMP: begin
					if (rpos < x_q) begin
						lo_q <= tib_pkg::N_W'(i_q) + tib_pkg::N_W'(1);
					end else begin
						hi1_q <= tib_pkg::N_W'(i_q);
					end
					state_q <= S_PROBE;
				end
				S_RD1: begin
					x0_q    <= rpos;
					v0_q    <= rval;
					state_q <= S_PAIR;
				end
				// upper entry present: bracket check
				S_PAIR: begin
					rgn_q <= tib_pkg::RGN_INTERP;
					if ((x0_q < x_q) && (x_q <= rpos)) begin
						dx_q    <= x_q - x0_q;
						dv_q    <= $signed({1'b0, rval}) - $signed({1'b0, v0_q});
						den_q   <= rpos - x0_q;
						state_q <= S_MUL;
					end else begin
						res_q   <= v0_q;
						state_q <= S_DONE;
					end
				end
				S_MUL: begin
					prod_q  <= $signed({1'b0, dx_q}) * dv_q;
					state_q <= S_DSTART;
				end
				S_DSTART: begin
					neg_q   <= prod_q[tib_pkg::DIVD_W+1];
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						res_q   <= interp_sum[tib_pkg::VAL_W-1:0];
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign region    = region_q;

	// checks
	`TIB_ASSERT(a_ready_div_idle, in_ready, !div_rsp.busy, "item accepted while divider busy")
	`TIB_ASSERT_NEXT(a_div_starts, div_req.start, div_rsp.busy, "divider did not start")
	`TIB_ASSERT(a_boundary_zero, out_valid && (region == tib_pkg::RGN_BOUNDARY), value == '0, "boundary item not zero")
	`TIB_ASSERT(a_series_cap, out_valid && (region == tib_pkg::RGN_SERIES), value <= tib_pkg::ONE_Q16, "series value above one")

endmodule

[verif/table_interpolator_binary_search_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// table_interpolator_binary_search_tb
// Loads breakpoint tables and sends queries through the valid/ready channels.
// A local copy of the table and the registers predicts each query's value and
// region, and the monitor compares every result item in order.
// ----------------------------------------------------------------------------
module table_interpolator_binary_search_tb;

	localparam int POS_MAX = (1 << tib_pkg::POS_W) - 1;

	typedef struct packed {
		logic                       op;
		logic [tib_pkg::IDX_W-1:0]  slot;
		logic [tib_pkg::POS_W-1:0]  pos;
		logic [tib_pkg::VAL_W-1:0]  val;
	} table_item_t;

	typedef struct packed {
		logic [tib_pkg::VAL_W-1:0]  value;
		logic [tib_pkg::RGN_W-1:0]  region;
	} answer_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic                         opcode = tib_pkg::OP_LOAD;
	logic [tib_pkg::IDX_W-1:0]    entry_index = '0;
	logic [tib_pkg::POS_W-1:0]    position = '0;
	logic [tib_pkg::VAL_W-1:0]    entry_value = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [tib_pkg::VAL_W-1:0]    value;
	logic [tib_pkg::RGN_W-1:0]    region;
	logic                         cfg_write = 1'b0;
	logic [tib_pkg::CIDX_W-1:0]   cfg_index = '0;
	logic [tib_pkg::CFG_W-1:0]    cfg_data = '0;

	// items waiting for the driver, answers waiting for the monitor
	table_item_t                  queued_items[$];
	answer_t                      pending_answers[$];
	table_item_t                  shown_item;

	// table and registers as the block should hold them
	logic [tib_pkg::POS_W-1:0]    knot_pos[tib_pkg::TABLE_DEPTH];
	logic [tib_pkg::VAL_W-1:0]    knot_val[tib_pkg::TABLE_DEPTH];
	logic [tib_pkg::CNT_W-1:0]    reg_count = tib_pkg::ENTRY_COUNT_RST;
	logic [tib_pkg::POS_W-1:0]    reg_bound = tib_pkg::BOUNDARY_RST;

	// table as the stimulus generator has planned it
	int                           plan_pos[tib_pkg::TABLE_DEPTH];
	int                           plan_val[tib_pkg::TABLE_DEPTH];
	int                           plan_bound = tib_pkg::BOUNDARY_RST;

	bit                           calm = 1'b0;
	int                           error_count = 0;

	table_interpolator_binary_search i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.entry_index (entry_index),
		.position    (position),
		.entry_value (entry_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.value       (value),
		.region      (region),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		if (error_count < 40) begin
			$display("MISMATCH at %0t: %s", $time, what);
		end
		error_count++;
	endtask

	// expected value and region of a query at position x
	function automatic answer_t lookup_value(input logic [tib_pkg::POS_W-1:0] x);
		int n, lo_i, hi_i, mid, k;
		longint x0, x1, v0, v1, xs, r;
		longint unsigned sq;
		answer_t a;
		n = int'(reg_count);
		if (n < 2) n = 2;
		if (n > tib_pkg::TABLE_DEPTH) n = tib_pkg::TABLE_DEPTH;
		if (x == '0 || x <= knot_pos[0]) begin
			// 1 - x^2/6 near the origin
			sq = (64'(x) * 64'(x)) / 64'(393216);
			a.value = (sq >= 64'(tib_pkg::ONE_Q16)) ? '0 :
			          tib_pkg::VAL_W'(64'(tib_pkg::ONE_Q16) - sq);
			a.region = tib_pkg::RGN_SERIES;
		end else if (x >= reg_bound) begin
			a.value = '0;
			a.region = tib_pkg::RGN_BOUNDARY;
		end else if (x >= knot_pos[n-1]) begin
			a.value = knot_val[n-1];
			a.region = tib_pkg::RGN_LAST;
		end else begin
			// lower-bound search, then the bracketing pair
			lo_i = 0;
			hi_i = n - 1;
			while (lo_i <= hi_i) begin
				mid = lo_i + (hi_i - lo_i) / 2;
				if (knot_pos[mid] < x) lo_i = mid + 1;
				else hi_i = mid - 1;
			end
			k = lo_i - 1;
			if (k < 0) k = 0;
			if (k > n - 2) k = n - 2;
			x0 = longint'(knot_pos[k]);
			x1 = longint'(knot_pos[k+1]);
			v0 = longint'(knot_val[k]);
			v1 = longint'(knot_val[k+1]);
			xs = longint'(x);
			// unordered pair falls back to the lower value
			if (!(x0 < xs && xs <= x1)) r = v0;
			else r = v0 + ((xs - x0) * (v1 - v0)) / (x1 - x0);
			a.value = r[tib_pkg::VAL_W-1:0];
			a.region = tib_pkg::RGN_INTERP;
		end
		return a;
	endfunction

	// driver: presents queued items, on acceptance updates the local table or queues the expected answer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= tib_pkg::OP_LOAD;
			entry_index <= '0;
			position <= '0;
			entry_value <= '0;
		end else begin
			if (in_valid && in_ready) begin
				if (shown_item.op == tib_pkg::OP_LOAD) begin
					knot_pos[shown_item.slot] = shown_item.pos;
					knot_val[shown_item.slot] = shown_item.val;
				end else begin
					pending_answers.insert(pending_answers.size(),
						lookup_value(shown_item.pos));
				end
			end
			if (!in_valid || in_ready) begin
				if (queued_items.size() != 0 && (calm || $urandom_range(0, 99) >= 24)) begin
					shown_item = queued_items.pop_front();
					in_valid <= 1'b1;
					opcode <= shown_item.op;
					entry_index <= shown_item.slot;
					position <= shown_item.pos;
					entry_value <= shown_item.val;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks result items against the oldest answer, stalls at random unless calm
	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_answers.size() == 0) begin
					report_mismatch($sformatf("result value %0d region %0d with no query open",
						value, region));
				end else begin
					want = pending_answers.pop_front();
					if (value !== want.value)
						report_mismatch($sformatf("value got %0d want %0d", value, want.value));
					if (region !== want.region)
						report_mismatch($sformatf("region got %0d want %0d", region, want.region));
				end
			end
			out_ready <= calm || ($urandom_range(0, 99) >= 24);
		end
	end

	function automatic int clip_pos(input int p);
		if (p < 0) return 0;
		if (p > POS_MAX) return POS_MAX;
		return p;
	endfunction

	function automatic int rand_value();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return int'(tib_pkg::ONE_Q16);
			default: return int'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic void push_item(input logic op, input int slot, input int pos, input int val);
		table_item_t it;
		it.op = op;
		it.slot = tib_pkg::IDX_W'(slot);
		it.pos = tib_pkg::POS_W'(pos);
		it.val = tib_pkg::VAL_W'(val);
		if (op == tib_pkg::OP_LOAD) begin
			plan_pos[slot] = pos;
			plan_val[slot] = val;
		end
		queued_items.insert(queued_items.size(), it);
	endfunction

	// waits until every item went in and every answer came out
	task automatic drain_all();
		do @(negedge clk);
		while (queued_items.size() != 0 || in_valid || pending_answers.size() != 0);
		// extra idle time before the next phase
		repeat (64) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [tib_pkg::CIDX_W-1:0] idx, input int data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= tib_pkg::CFG_W'(data);
		if (idx == tib_pkg::CFG_ENTRY_COUNT) reg_count = tib_pkg::CNT_W'(data);
		else reg_bound = tib_pkg::POS_W'(data);
		@(posedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// one setting: mode 0 ascending, 1 ascending with repeats, 2 unordered;
	// a negative bound is drawn at random, mostly just past the last entry
	task automatic run_phase(input int count_reg, input int mode, input int bnd,
			input int n_items, input bit do_fill);
		int n, lo, hi, pick, s, x, stride_max;
		n = count_reg;
		if (n < 2) n = 2;
		if (n > tib_pkg::TABLE_DEPTH) n = tib_pkg::TABLE_DEPTH;
		if (do_fill) begin
			stride_max = 400000 / n;
			for (int i = 0; i < n; i++) begin
				if (mode == 2) plan_pos[i] = $urandom_range(0, POS_MAX);
				else if (i == 0) plan_pos[i] = $urandom_range(0, 100000);
				else if (mode == 1 && $urandom_range(0, 99) < 8) plan_pos[i] = plan_pos[i-1];
				else plan_pos[i] = plan_pos[i-1] + int'($urandom_range(1, stride_max));
				plan_val[i] = rand_value();
			end
		end
		lo = plan_pos[0];
		hi = plan_pos[n-1];
		if (bnd >= 0) plan_bound = bnd;
		else begin
			pick = $urandom_range(0, 9);
			if (pick < 6) plan_bound = clip_pos(hi + int'($urandom_range(1, 20000)));
			else if (pick < 8) plan_bound = $urandom_range(0, POS_MAX);
			else plan_bound = $urandom_range(lo, hi);
		end
		write_reg(tib_pkg::CFG_ENTRY_COUNT, count_reg);
		write_reg(tib_pkg::CFG_BOUNDARY, plan_bound);
		if (do_fill) begin
			for (int i = 0; i < n; i++) push_item(tib_pkg::OP_LOAD, i, plan_pos[i], plan_val[i]);
		end
		for (int k = 0; k < n_items; k++) begin
			pick = $urandom_range(0, 99);
			lo = plan_pos[0];
			hi = plan_pos[n-1];
			if (pick < 12) begin
				// reload of a slot in use, may break the ordering
				s = $urandom_range(0, n - 1);
				push_item(tib_pkg::OP_LOAD, s,
					clip_pos(plan_pos[s] + int'($urandom_range(0, 4000)) - 2000), rand_value());
			end else if (pick < 17) begin
				push_item(tib_pkg::OP_LOAD, $urandom_range(0, tib_pkg::TABLE_DEPTH - 1),
					$urandom_range(0, POS_MAX), rand_value());
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 35 && hi > lo + 1) x = $urandom_range(lo + 1, hi - 1);
				else if (pick < 55) begin
					s = $urandom_range(0, n - 1);
					x = plan_pos[s] + int'($urandom_range(0, 2)) - 1;
				end else if (pick < 70) x = $urandom_range(0, POS_MAX);
				else if (pick < 80) x = $urandom_range(0, lo);
				else if (pick < 90) x = plan_bound + int'($urandom_range(0, 2)) - 1;
				else begin
					case ($urandom_range(0, 3))
						0: x = 0;
						1: x = POS_MAX;
						2: x = lo;
						default: x = hi;
					endcase
				end
				push_item(tib_pkg::OP_QUERY, $urandom_range(0, tib_pkg::TABLE_DEPTH - 1),
					clip_pos(x), rand_value());
			end
		end
		drain_all();
	endtask

	// run limit
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset registers: two entries, boundary just above 3.6537
		push_item(tib_pkg::OP_LOAD, 0, 65536, 0);
		push_item(tib_pkg::OP_LOAD, 1, 196608, 65536);
		push_item(tib_pkg::OP_QUERY, 0, 0, 0);
		push_item(tib_pkg::OP_QUERY, 0, 1, 0);
		push_item(tib_pkg::OP_QUERY, 0, 65535, 0);
		push_item(tib_pkg::OP_QUERY, 0, 65536, 0);
		push_item(tib_pkg::OP_QUERY, 0, 65537, 0);
		push_item(tib_pkg::OP_QUERY, 0, 131072, 0);
		push_item(tib_pkg::OP_QUERY, 0, 196607, 0);
		push_item(tib_pkg::OP_QUERY, 0, 196608, 0);
		push_item(tib_pkg::OP_QUERY, 0, 200000, 0);
		push_item(tib_pkg::OP_QUERY, 0, 239453, 0);
		push_item(tib_pkg::OP_QUERY, 0, 239454, 0);
		push_item(tib_pkg::OP_QUERY, tib_pkg::TABLE_DEPTH - 1, POS_MAX, 65536);
		// falling slope, truncation toward zero
		push_item(tib_pkg::OP_LOAD, 0, 65536, 65536);
		push_item(tib_pkg::OP_LOAD, 1, 196608, 0);
		push_item(tib_pkg::OP_QUERY, 0, 100001, 0);
		push_item(tib_pkg::OP_QUERY, 0, 65537, 0);
		// last entry past the boundary
		push_item(tib_pkg::OP_LOAD, 1, POS_MAX, 1);
		push_item(tib_pkg::OP_QUERY, 0, 300000, 0);
		push_item(tib_pkg::OP_QUERY, 0, 239453, 0);
		// first breakpoint at zero
		push_item(tib_pkg::OP_LOAD, 0, 0, 65536);
		push_item(tib_pkg::OP_QUERY, 0, 0, 0);
		push_item(tib_pkg::OP_QUERY, 0, 1, 0);
		drain_all();

		// small tables, entry counts below range included
		run_phase(0, 0, -1, 20, 1'b1);
		run_phase(1, 2, 0, 15, 1'b1);
		run_phase(5, 2, -1, 20, 1'b1);
		run_phase($urandom_range(3, 16), 1, POS_MAX, 20, 1'b1);
		run_phase($urandom_range(3, 16), 0, -1, 20, 1'b1);
		run_phase($urandom_range(3, 16), 0, -1, 20, 1'b1);

		// full table, entry count above range, no idling on either side, then runs with stalls and no refill
		calm = 1'b1;
		run_phase(1023, 0, -1, 30, 1'b1);
		calm = 1'b0;
		run_phase(512, 0, POS_MAX, 16, 1'b0);
		run_phase($urandom_range(100, 400), 0, -1, 16, 1'b0);

		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
